// File: hdl/fdtd_pkg.sv
// Shared types, constants and fixed-point helpers for the FDTD grid step block.
package fdtd_pkg;

  localparam logic signed [31:0] ONE_Q = 32'sh0100_0000;
  localparam logic signed [47:0] MAX48 = 48'sd2147483647;
  localparam logic signed [47:0] MIN48 = -48'sd2147483648;

  localparam logic [2:0] KIND_CELL = 3'd0;
  localparam logic [2:0] KIND_ROW  = 3'd1;
  localparam logic [2:0] KIND_COL  = 3'd2;
  localparam logic [2:0] KIND_STEP = 3'd3;
  localparam logic [2:0] KIND_READ = 3'd4;

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [5:0]  index_x;
    logic        [5:0]  index_y;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic signed [31:0] value_e;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] field_ez;
    logic signed [31:0] field_hx;
    logic signed [31:0] field_hy;
    logic               saturated;
  } res_t;

  // One grid cell: all per-cell state in one memory word.
  typedef struct packed {
    logic signed [31:0] ez;
    logic signed [31:0] dz;
    logic signed [31:0] iz;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [31:0] ihx;
    logic signed [31:0] ihy;
    logic signed [31:0] ca;
    logic signed [31:0] cb;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] g2;
    logic signed [31:0] g3;
    logic signed [31:0] f1;
    logic signed [31:0] f2;
    logic signed [31:0] f3;
  } prof_t;

  localparam cell_t CELL_INIT = '{ez: '0, dz: '0, iz: '0, hx: '0, hy: '0,
                                  ihx: '0, ihy: '0, ca: ONE_Q, cb: '0};
  localparam prof_t PROF_INIT = '{g2: ONE_Q, g3: ONE_Q, f1: '0, f2: ONE_Q, f3: ONE_Q};

  typedef enum logic [1:0] {PASS_D, PASS_E, PASS_H} pass_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_LOAD_WR, ST_READ_CAP,
    ST_SWEEP, ST_DRAIN, ST_SRC_RD, ST_SRC_WR, ST_DONE
  } state_t;

  typedef struct packed {
    logic  valid;
    logic  interior;
    pass_t pass;
  } upd_tag_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sval_t;

  function automatic logic signed [47:0] x32(input logic signed [31:0] v);
    return {{16{v[31]}}, v};
  endfunction

  function automatic logic signed [47:0] x36(input logic signed [35:0] v);
    return {{12{v[35]}}, v};
  endfunction

  function automatic logic signed [47:0] x40(input logic signed [39:0] v);
    return {{8{v[39]}}, v};
  endfunction

  function automatic logic signed [35:0] s36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  function automatic sval_t clamp48(input logic signed [47:0] v);
    sval_t r;
    if (v > MAX48) begin
      r.sat = 1'b1;
      r.val = 32'sh7fff_ffff;
    end else if (v < MIN48) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Product rounded half up and floor-shifted by 24.
  function automatic logic signed [39:0] mul_exact(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd8388608;
    return p[63:24];
  endfunction

  function automatic sval_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
    return clamp48(x40(mul_exact(a, b)));
  endfunction

  function automatic sval_t half_of(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = v + 36'sd1;
    t = t >>> 1;
    return clamp48(x36(t));
  endfunction

endpackage

// File: hdl/fdtd_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module fdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hdl/fdtd_upd.sv
// Cell update pipeline for the D, E and H sweeps: four stages, write back at the end.
module fdtd_upd import fdtd_pkg::*; #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  upd_tag_t      tag,
  input  logic [AW-1:0] addr,
  input  cell_t         rd_a,
  input  cell_t         rd_b,
  input  prof_t         rp,
  input  prof_t         cp,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output cell_t         wr_data,
  output logic          sat_hit
);

  // rd_a is the word after the cell; the two earlier reads are the cell and its predecessor
  cell_t prev1, prev2;

  upd_tag_t           t1, t2, t3;
  logic [AW-1:0]      a1, a2, a3;
  cell_t              w1, w2, w3;
  logic               sat1, sat2, sat3;
  logic signed [31:0] ma1 [6];
  logic signed [31:0] mb1 [6];
  logic signed [39:0] p2 [6];
  logic signed [39:0] q3;

  cell_t              w_s1, w_s3;
  logic signed [31:0] ma_s1 [6];
  logic signed [31:0] mb_s1 [6];
  logic               sat_s1, sat_s3, sat_s4;
  logic signed [39:0] q_s3;

  sval_t              g3, g2, hc, diff, ihy, ihx, hyh, hxh, sd, shy, shx, se, siz;
  logic signed [35:0] curl, cy, cx;

  always_ff @(posedge clk) begin
    prev1 <= rd_a;
    prev2 <= prev1;
  end

  // Stage 1: curls, differences, coefficient products
  always_comb begin
    w_s1   = prev1;
    sat_s1 = 1'b0;
    for (int i = 0; i < 6; i++) begin
      ma_s1[i] = '0;
      mb_s1[i] = '0;
    end
    curl = s36(prev1.hy) - s36(rd_b.hy) - s36(prev1.hx) + s36(prev2.hx);
    g3   = qmul(rp.g3, cp.g3);
    g2   = qmul(rp.g2, cp.g2);
    hc   = half_of(curl);
    diff = clamp48(x32(prev1.dz) - x32(prev1.iz));
    cy   = s36(rd_b.ez) - s36(prev1.ez);
    cx   = s36(prev1.ez) - s36(rd_a.ez);
    ihy  = clamp48(x32(prev1.ihy) + x36(cy));
    ihx  = clamp48(x32(prev1.ihx) + x36(cx));
    hyh  = half_of(cy);
    hxh  = half_of(cx);
    case (tag.pass)
      PASS_D: begin
        ma_s1[0] = g3.val;
        mb_s1[0] = prev1.dz;
        ma_s1[1] = g2.val;
        mb_s1[1] = hc.val;
        sat_s1   = g3.sat | g2.sat | hc.sat;
      end
      PASS_E: begin
        ma_s1[0] = prev1.ca;
        mb_s1[0] = diff.val;
        sat_s1   = diff.sat;
      end
      PASS_H: begin
        w_s1.ihy = ihy.val;
        w_s1.ihx = ihx.val;
        ma_s1[0] = rp.f3;
        mb_s1[0] = prev1.hy;
        ma_s1[1] = rp.f2;
        mb_s1[1] = hyh.val;
        ma_s1[2] = cp.f1;
        mb_s1[2] = ihy.val;
        ma_s1[3] = cp.f3;
        mb_s1[3] = prev1.hx;
        ma_s1[4] = cp.f2;
        mb_s1[4] = hxh.val;
        ma_s1[5] = rp.f1;
        mb_s1[5] = ihx.val;
        sat_s1   = ihy.sat | ihx.sat | hyh.sat | hxh.sat;
      end
      default: begin
        sat_s1 = 1'b0;
      end
    endcase
  end

  // Stage 3: sums of products; the E pass also forms cb*Ez
  always_comb begin
    w_s3   = w2;
    sat_s3 = 1'b0;
    sd     = clamp48(x40(p2[0]) + x40(p2[1]));
    shy    = clamp48(x40(p2[0]) + x40(p2[1]) + x40(p2[2]));
    shx    = clamp48(x40(p2[3]) + x40(p2[4]) + x40(p2[5]));
    se     = clamp48(x40(p2[0]));
    q_s3   = mul_exact(w2.cb, se.val);
    case (t2.pass)
      PASS_D: begin
        w_s3.dz = sd.val;
        sat_s3  = sd.sat;
      end
      PASS_E: begin
        w_s3.ez = se.val;
        sat_s3  = se.sat;
      end
      PASS_H: begin
        w_s3.hy = shy.val;
        w_s3.hx = shx.val;
        sat_s3  = shy.sat | shx.sat;
      end
      default: begin
        sat_s3 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
    end else begin
      t1.valid <= tag.valid;
      t2.valid <= t1.valid;
      t3.valid <= t2.valid;
    end
    t1.interior <= tag.interior;
    t1.pass     <= tag.pass;
    t2.interior <= t1.interior;
    t2.pass     <= t1.pass;
    t3.interior <= t2.interior;
    t3.pass     <= t2.pass;
    a1   <= addr;
    a2   <= a1;
    a3   <= a2;
    w1   <= w_s1;
    w2   <= w1;
    w3   <= w_s3;
    sat1 <= sat_s1;
    sat2 <= sat1;
    sat3 <= sat2 | sat_s3;
    q3   <= q_s3;
    for (int i = 0; i < 6; i++) begin
      ma1[i] <= ma_s1[i];
      mb1[i] <= mb_s1[i];
      p2[i]  <= mul_exact(ma1[i], mb1[i]);
    end
  end

  // Stage 4: conduction integral for the E pass, then write back
  always_comb begin
    wr_data = w3;
    siz     = clamp48(x32(w3.iz) + x40(q3));
    sat_s4  = 1'b0;
    if (t3.pass == PASS_E) begin
      wr_data.iz = siz.val;
      sat_s4     = siz.sat;
    end
    wr_en   = t3.valid & t3.interior;
    wr_addr = a3;
    sat_hit = wr_en & (sat3 | sat_s4);
  end

endmodule

// File: hdl/fdtd_2d_tm_pml_step.sv
// Top level of the 2-D TM FDTD grid with PML profiles: control, memories, result register.
//
//   channel | ports                      | payload
//   --------+----------------------------+-----------------------------------------
//   command | cmd_valid, cmd_stall, cmd  | kind, index_x, index_y, value_a..value_e
//   result  | res_valid, res_stall, res  | field_ez, field_hx, field_hy, saturated
//
// Cycles from one command transfer to the earliest next one: 4 for a cell load or a read,
// 3 for a profile load or an unused kind, 3*(GRID_X*GRID_Y + 5) + 5 for a timestep (one
// fewer when the source lands off the interior). The timestep is set by the sweeps: each
// of the D, E and H passes reads one cell word per cycle through port A, then drains.
// Reset: after rst a clearing pass of GRID_X*GRID_Y cycles writes the initial values into
// both memories; cmd_stall stays high during it.
// Stalls: one command is in work at a time; a new transfer is taken while the previous
// result still waits in the result register, and the next result holds until it leaves.
module fdtd_2d_tm_pml_step import fdtd_pkg::*; #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int CELLS = GRID_X * GRID_Y;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int PD    = GRID_X + GRID_Y;
  localparam int PAW   = $clog2(PD);

  state_t st, st_next;

  cmd_t           cmd_r;
  pass_t          pass;
  logic [SW-1:0]  s;
  logic [XW-1:0]  xs, xc;
  logic [YW-1:0]  ys, yc;
  logic [1:0]     drn;
  logic           sat_acc;
  logic signed [31:0] ez_r, hx_r, hy_r;

  // memory ports
  logic           cram_we;
  logic [AW-1:0]  cram_waddr, cram_raddr_a, cram_raddr_b;
  cell_t          cram_wdata, cram_rd_a, cram_rd_b;
  logic           pram_we;
  logic [PAW-1:0] pram_waddr, pram_raddr_a, pram_raddr_b;
  prof_t          pram_wdata, pram_rd_a, pram_rd_b;

  // sweep pipeline
  upd_tag_t       tag0, tag_issue;
  logic [AW-1:0]  a0;
  logic           upd_we, upd_sat;
  logic [AW-1:0]  upd_waddr;
  cell_t          upd_wdata;

  // command decode
  logic           in_grid, row_ok, col_ok, src_ok, interior_c;
  logic [AW-1:0]  cell_addr, src_addr;
  cell_t          load_word, src_word;
  sval_t          src_sum;

  assign cmd_stall = (st != ST_IDLE);

  assign row_ok = 32'(cmd_r.index_x) < 32'(GRID_X);
  assign col_ok = 32'(cmd_r.index_y) < 32'(GRID_Y);
  assign in_grid = row_ok & col_ok;
  assign src_ok = (cmd_r.index_x != '0) && (32'(cmd_r.index_x) < 32'(GRID_X - 1)) &&
                  (cmd_r.index_y != '0) && (32'(cmd_r.index_y) < 32'(GRID_Y - 1));
  assign cell_addr = AW'(32'(cmd_r.index_x) * 32'(GRID_Y) + 32'(cmd_r.index_y));
  assign src_addr  = cell_addr;

  assign interior_c = (xc != '0) && (xc != XW'(GRID_X - 1)) &&
                      (yc != '0) && (yc != YW'(GRID_Y - 1));

  always_comb begin
    load_word    = cram_rd_a;
    load_word.ca = cmd_r.value_a;
    load_word.cb = cmd_r.value_b;
    src_sum      = clamp48(x32(cram_rd_a.ez) + x32(cmd_r.value_a));
    src_word     = cram_rd_a;
    src_word.ez  = src_sum.val;
  end

  fdtd_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_cell_ram (
    .clk     (clk),
    .we      (cram_we),
    .waddr   (cram_waddr),
    .wdata   (cram_wdata),
    .raddr_a (cram_raddr_a),
    .rdata_a (cram_rd_a),
    .raddr_b (cram_raddr_b),
    .rdata_b (cram_rd_b)
  );

  // rows at 0..GRID_X-1, columns at GRID_X..GRID_X+GRID_Y-1
  fdtd_ram #(.WIDTH($bits(prof_t)), .DEPTH(PD)) u_prof_ram (
    .clk     (clk),
    .we      (pram_we),
    .waddr   (pram_waddr),
    .wdata   (pram_wdata),
    .raddr_a (pram_raddr_a),
    .rdata_a (pram_rd_a),
    .raddr_b (pram_raddr_b),
    .rdata_b (pram_rd_b)
  );

  fdtd_upd #(.AW(AW)) u_upd (
    .clk     (clk),
    .rst     (rst),
    .tag     (tag0),
    .addr    (a0),
    .rd_a    (cram_rd_a),
    .rd_b    (cram_rd_b),
    .rp      (pram_rd_a),
    .cp      (pram_rd_b),
    .wr_en   (upd_we),
    .wr_addr (upd_waddr),
    .wr_data (upd_wdata),
    .sat_hit (upd_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  // Next state and memory port control
  always_comb begin
    st_next      = st;
    cram_we      = upd_we;
    cram_waddr   = upd_waddr;
    cram_wdata   = upd_wdata;
    cram_raddr_a = '0;
    cram_raddr_b = '0;
    pram_we      = 1'b0;
    pram_waddr   = '0;
    pram_wdata   = PROF_INIT;
    pram_raddr_a = PAW'(xc);
    pram_raddr_b = PAW'(32'(GRID_X) + 32'(yc));
    tag_issue    = '{valid: 1'b0, interior: interior_c, pass: pass};
    unique case (st)
      ST_CLEAR: begin
        cram_we    = 1'b1;
        cram_waddr = AW'(s);
        cram_wdata = CELL_INIT;
        pram_we    = 32'(s) < PD;
        pram_waddr = PAW'(s);
        if (s == SW'(CELLS - 1)) begin
          st_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          st_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (cmd_r.kind)
          KIND_CELL: begin
            cram_raddr_a = cell_addr;
            st_next      = in_grid ? ST_LOAD_WR : ST_DONE;
          end
          KIND_ROW: begin
            pram_we    = row_ok;
            pram_waddr = PAW'(cmd_r.index_x);
            pram_wdata = '{g2: cmd_r.value_a, g3: cmd_r.value_b, f1: cmd_r.value_c,
                           f2: cmd_r.value_d, f3: cmd_r.value_e};
            st_next    = ST_DONE;
          end
          KIND_COL: begin
            pram_we    = col_ok;
            pram_waddr = PAW'(32'(GRID_X) + 32'(cmd_r.index_y));
            pram_wdata = '{g2: cmd_r.value_a, g3: cmd_r.value_b, f1: cmd_r.value_c,
                           f2: cmd_r.value_d, f3: cmd_r.value_e};
            st_next    = ST_DONE;
          end
          KIND_STEP: begin
            st_next = ST_SWEEP;
          end
          KIND_READ: begin
            cram_raddr_a = cell_addr;
            st_next      = in_grid ? ST_READ_CAP : ST_DONE;
          end
          default: begin
            st_next = ST_DONE;
          end
        endcase
      end
      ST_LOAD_WR: begin
        cram_we    = 1'b1;
        cram_waddr = cell_addr;
        cram_wdata = load_word;
        st_next    = ST_DONE;
      end
      ST_READ_CAP: begin
        st_next = ST_DONE;
      end
      ST_SWEEP: begin
        // step s works on cell s-1; port A runs one word ahead
        tag_issue.valid = (s != '0);
        if (32'(s) < CELLS) begin
          cram_raddr_a = AW'(s);
        end
        if (pass == PASS_D) begin
          if (32'(s) >= GRID_Y + 1) begin
            cram_raddr_b = AW'(32'(s) - 32'(GRID_Y + 1));
          end
        end else if (32'(s) + 32'(GRID_Y) - 32'd1 < CELLS) begin
          cram_raddr_b = AW'(32'(s) + 32'(GRID_Y) - 32'd1);
        end
        if (s == SW'(CELLS)) begin
          st_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drn == 2'd3) begin
          case (pass)
            PASS_D:  st_next = ST_SWEEP;
            PASS_E:  st_next = ST_SRC_RD;
            default: st_next = ST_DONE;
          endcase
        end
      end
      ST_SRC_RD: begin
        cram_raddr_a = src_addr;
        st_next      = src_ok ? ST_SRC_WR : ST_SWEEP;
      end
      ST_SRC_WR: begin
        cram_we    = 1'b1;
        cram_waddr = src_addr;
        cram_wdata = src_word;
        st_next    = ST_SWEEP;
      end
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  // Counters, command latch, result assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      s         <= '0;
      drn       <= '0;
      pass      <= PASS_D;
      tag0      <= '{valid: 1'b0, interior: 1'b0, pass: PASS_D};
      res_valid <= 1'b0;
    end else begin
      tag0 <= tag_issue;
      // drop the result once it transfers, unless a new one replaces it this cycle
      if (res_valid && !res_stall && st != ST_DONE) begin
        res_valid <= 1'b0;
      end
      case (st)
        ST_CLEAR: begin
          s <= (s == SW'(CELLS - 1)) ? '0 : s + 1'b1;
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            sat_acc <= 1'b0;
            ez_r    <= '0;
            hx_r    <= '0;
            hy_r    <= '0;
            s       <= '0;
            xs      <= '0;
            ys      <= '0;
            drn     <= '0;
            pass    <= PASS_D;
          end
        end
        ST_READ_CAP: begin
          ez_r <= cram_rd_a.ez;
          hx_r <= cram_rd_a.hx;
          hy_r <= cram_rd_a.hy;
        end
        ST_SWEEP: begin
          s  <= s + 1'b1;
          xc <= xs;
          yc <= ys;
          if (ys == YW'(GRID_Y - 1)) begin
            ys <= '0;
            xs <= xs + 1'b1;
          end else begin
            ys <= ys + 1'b1;
          end
          if (upd_sat) begin
            sat_acc <= 1'b1;
          end
        end
        ST_DRAIN: begin
          drn <= drn + 1'b1;
          if (drn == 2'd3) begin
            s  <= '0;
            xs <= '0;
            ys <= '0;
            if (pass == PASS_D) begin
              pass <= PASS_E;
            end else begin
              pass <= PASS_H;
            end
          end
          if (upd_sat) begin
            sat_acc <= 1'b1;
          end
        end
        ST_SRC_WR: begin
          sat_acc <= sat_acc | src_sum.sat;
        end
        ST_DONE: begin
          if (!res_valid || !res_stall) begin
            res       <= '{field_ez: ez_r, field_hx: hx_r, field_hy: hy_r,
                           saturated: sat_acc};
            res_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    a0 <= AW'(32'(s) - 32'd1);
  end

endmodule

// File: tb/tb_fdtd_2d_tm_pml_step.sv
// Self-checking testbench for the 2-D TM FDTD grid step block with PML profiles.
module tb_fdtd_2d_tm_pml_step;
  import fdtd_pkg::*;

  localparam int NX = 64;
  localparam int NY = 64;
  localparam int N_RANDOM = 100;
  localparam int IDLE_LIMIT = 60000;   // longer than a full timestep
  localparam logic [2:0] KIND_SPARE = 3'd5;  // first unused kind; 6 and 7 follow
  localparam int PG2 = 0, PG3 = 1, PF1 = 2, PF2 = 3, PF3 = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  always #4 clk = ~clk;

  fdtd_2d_tm_pml_step #(.GRID_X(NX), .GRID_Y(NY)) i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // Shadow grid state; cell index is x*NY + y.
  int ez_m[NX*NY], dz_m[NX*NY], iz_m[NX*NY], hx_m[NX*NY], hy_m[NX*NY];
  int ihx_m[NX*NY], ihy_m[NX*NY], ca_m[NX*NY], cb_m[NX*NY];
  int rowp[NX][5], colp[NY][5];
  bit sat_seen;

  res_t expected_q[$];     // results still owed by the block
  bit   typed_flag_q[$];   // per transfer: use the typed-in result
  res_t typed_res_q[$];
  int   n_errors = 0;
  int   idle_cycles = 0;
  int   src_x = 20, src_y = 20;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  function automatic longint qprod(int a, int b);
    return (longint'(a) * longint'(b) + 64'sd8388608) >>> 24;
  endfunction

  function automatic int halved(longint v);
    return sat32((v + 1) >>> 1);
  endfunction

  function automatic void reset_grid();
    for (int c = 0; c < NX*NY; c++) begin
      ez_m[c] = 0; dz_m[c] = 0; iz_m[c] = 0; hx_m[c] = 0; hy_m[c] = 0;
      ihx_m[c] = 0; ihy_m[c] = 0; ca_m[c] = ONE_Q; cb_m[c] = 0;
    end
    for (int k = 0; k < NX; k++) rowp[k] = '{ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q};
    for (int k = 0; k < NY; k++) colp[k] = '{ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q};
  endfunction

  // Advance the shadow grid by one timestep: D sweep, E sweep, source, H sweep.
  function automatic void advance_grid(int src, int sx, int sy);
    int c, g2, g3;
    longint curl;
    for (int x = 1; x < NX-1; x++)
      for (int y = 1; y < NY-1; y++) begin
        c = x*NY + y;
        curl = longint'(hy_m[c]) - hy_m[c-NY] - hx_m[c] + hx_m[c-1];
        g3 = sat32(qprod(rowp[x][PG3], colp[y][PG3]));
        g2 = sat32(qprod(rowp[x][PG2], colp[y][PG2]));
        dz_m[c] = sat32(qprod(g3, dz_m[c]) + qprod(g2, halved(curl)));
      end
    for (int x = 1; x < NX-1; x++)
      for (int y = 1; y < NY-1; y++) begin
        c = x*NY + y;
        ez_m[c] = sat32(qprod(ca_m[c], sat32(longint'(dz_m[c]) - iz_m[c])));
        iz_m[c] = sat32(longint'(iz_m[c]) + qprod(cb_m[c], ez_m[c]));
      end
    if (sx >= 1 && sx < NX-1 && sy >= 1 && sy < NY-1) begin
      c = sx*NY + sy;
      ez_m[c] = sat32(longint'(ez_m[c]) + src);
    end
    for (int x = 1; x < NX-1; x++)
      for (int y = 1; y < NY-1; y++) begin
        c = x*NY + y;
        curl = longint'(ez_m[c+NY]) - ez_m[c];
        ihy_m[c] = sat32(longint'(ihy_m[c]) + curl);
        hy_m[c] = sat32(qprod(rowp[x][PF3], hy_m[c]) + qprod(rowp[x][PF2], halved(curl))
                        + qprod(colp[y][PF1], ihy_m[c]));
        curl = longint'(ez_m[c]) - ez_m[c+1];
        ihx_m[c] = sat32(longint'(ihx_m[c]) + curl);
        hx_m[c] = sat32(qprod(colp[y][PF3], hx_m[c]) + qprod(colp[y][PF2], halved(curl))
                        + qprod(rowp[x][PF1], ihx_m[c]));
      end
  endfunction

  function automatic res_t apply_command(cmd_t t);
    res_t r;
    int c;
    r = '0;
    sat_seen = 1'b0;
    c = int'(t.index_x)*NY + int'(t.index_y);
    case (t.kind)
      KIND_CELL: begin
        ca_m[c] = t.value_a;
        cb_m[c] = t.value_b;
      end
      KIND_ROW: rowp[t.index_x] = '{t.value_a, t.value_b, t.value_c, t.value_d, t.value_e};
      KIND_COL: colp[t.index_y] = '{t.value_a, t.value_b, t.value_c, t.value_d, t.value_e};
      KIND_STEP: advance_grid(t.value_a, int'(t.index_x), int'(t.index_y));
      KIND_READ: begin
        r.field_ez = ez_m[c];
        r.field_hx = hx_m[c];
        r.field_hy = hy_m[c];
      end
      default: ;
    endcase
    r.saturated = sat_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    n_errors++;
  endtask

  // Accept side: predict on every command transfer, check every result transfer.
  always @(posedge clk) begin
    res_t want, pred;
    if (!rst && cmd_valid && !cmd_stall) begin
      pred = apply_command(cmd);
      if (typed_flag_q.size() != 0 && typed_flag_q.pop_front()) pred = typed_res_q.pop_front();
      expected_q = {expected_q, pred};
    end
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", res.field_ez, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (res.field_ez !== want.field_ez) report_mismatch("field_ez", res.field_ez, want.field_ez);
        if (res.field_hx !== want.field_hx) report_mismatch("field_hx", res.field_hx, want.field_hx);
        if (res.field_hy !== want.field_hy) report_mismatch("field_hy", res.field_hy, want.field_hy);
        if (res.saturated !== want.saturated)
          report_mismatch("saturated", 32'(res.saturated), 32'(want.saturated));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_fdtd_2d_tm_pml_step NOT OK");
      $finish;
    end
  end

  // Result stall: bursts of stall or no stall, mostly short, sometimes long.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      res_stall <= ($urandom_range(0, 2) == 0);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one command and hold it until transfer; then idle for a random gap, which may be zero.
  task automatic drive_command(cmd_t t, bit typed, res_t typed_res);
    int gap;
    typed_flag_q = {typed_flag_q, typed};
    if (typed) typed_res_q = {typed_res_q, typed_res};
    cmd <= t;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    gap = random_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Q8.24 values: full range, near one, extremes or zero.
  function automatic logic [31:0] random_q();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 0;
      default: return ONE_Q - 32'h0040_0000 + $urandom_range(0, 32'h0080_0000);
    endcase
  endfunction

  function automatic cmd_t mk(logic [2:0] k, int x, int y, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c = 0, logic [31:0] d = 0, logic [31:0] e = 0);
    cmd_t t;
    t.kind = k; t.index_x = 6'(x); t.index_y = 6'(y);
    t.value_a = a; t.value_b = b; t.value_c = c; t.value_d = d; t.value_e = e;
    return t;
  endfunction

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    cmd_t t;
    int pick;
    res_t none;
    none = '0;
    reset_grid();
    // Directed table: typed rows carry their result, the rest use the predictor.
    rows = '{
      '{mk(KIND_READ, 5, 5, 0, 0), 1, none},
      '{mk(KIND_READ, 63, 63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
           32'hffff_ffff, 32'hffff_ffff), 1, none},
      '{mk(KIND_SPARE, 7, 9, 32'h1234_5678, 1), 1, none},
      '{mk(KIND_SPARE + 3'd1, 63, 0, 32'h7fff_ffff, 0), 1, none},
      '{mk(KIND_SPARE + 3'd2, 0, 63, 32'h8000_0000, 0), 1, none},
      '{mk(KIND_STEP, 5, 5, 32'h7fff_ffff, 0), 0, none},
      '{mk(KIND_READ, 5, 5, 0, 0), 0, none},
      '{mk(KIND_READ, 6, 5, 0, 0), 0, none},
      '{mk(KIND_READ, 5, 4, 0, 0), 0, none},
      // boundary cell load is stored but never updated
      '{mk(KIND_CELL, 0, 0, 32'h7fff_ffff, 32'h8000_0000), 1, none},
      '{mk(KIND_CELL, 63, 63, 32'h8000_0000, 32'h7fff_ffff), 1, none},
      '{mk(KIND_CELL, 6, 6, 32'h7fff_ffff, 32'h0010_0000), 1, none},
      '{mk(KIND_ROW, 6, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0100_0000,
           32'h8000_0000, 32'h7fff_ffff), 1, none},
      '{mk(KIND_COL, 0, 6, ONE_Q, 32'h00f0_0000, 32'h0008_0000,
           ONE_Q, 32'h00e0_0000), 1, none},
      // source on a boundary cell is dropped
      '{mk(KIND_STEP, 0, 5, 32'h7fff_ffff, 0), 0, none},
      '{mk(KIND_STEP, 63, 20, 32'h8000_0000, 0), 0, none},
      '{mk(KIND_STEP, 6, 6, 32'h8000_0000, 0), 0, none},
      '{mk(KIND_READ, 6, 6, 0, 0), 0, none},
      '{mk(KIND_READ, 5, 6, 0, 0), 0, none},
      '{mk(KIND_READ, 0, 0, 0, 0), 0, none},
      '{mk(KIND_READ, 63, 63, 0, 0), 0, none},
      '{mk(KIND_ROW, 63, 0, ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q), 1, none},
      '{mk(KIND_COL, 0, 63, ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q), 1, none}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) drive_command(rows[i].c, rows[i].typed, rows[i].r);

    for (int n = 0; n < N_RANDOM; n++) begin
      // hold off once until the block has drained
      if (n == N_RANDOM/2) begin
        cmd_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 19);
      t = mk(3'($urandom_range(0, 7)), int'($urandom_range(0, 63)),
             int'($urandom_range(0, 63)),
             random_q(), random_q(), random_q(), random_q(), random_q());
      if (pick < 3) begin
        t.kind = KIND_STEP;
        if ($urandom_range(0, 3) != 0) begin
          src_x = $urandom_range(1, NX-2);
          src_y = $urandom_range(1, NY-2);
          t.index_x = 6'(src_x);
          t.index_y = 6'(src_y);
        end
      end else if (pick < 11) begin
        t.kind = KIND_READ;
        if ($urandom_range(0, 3) != 0) begin
          t.index_x = 6'(src_x + int'($urandom_range(0, 4)) - 2);
          t.index_y = 6'(src_y + int'($urandom_range(0, 4)) - 2);
        end
      end else if (pick < 14) begin
        t.kind = KIND_CELL;
        t.value_b = $urandom_range(0, 1) ? random_q() : $urandom_range(0, 32'h0020_0000);
      end else if (pick < 17) begin
        t.kind = $urandom_range(0, 1) ? KIND_ROW : KIND_COL;
        if ($urandom_range(0, 2) != 0) t.value_c = $urandom_range(0, 32'h0010_0000);
      end
      drive_command(t, 0, none);
    end
    cmd_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("tb_fdtd_2d_tm_pml_step OK");
    end else begin
      $display("tb_fdtd_2d_tm_pml_step NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/fdtd_pkg.sv
hdl/fdtd_ram.sv
hdl/fdtd_upd.sv
hdl/fdtd_2d_tm_pml_step.sv
tb/tb_fdtd_2d_tm_pml_step.sv
